// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl of the box placement block
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on the rising clock, off while reset is low
`define BPOC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bpoc assertion failed");

// antecedent and consequent in the same cycle
`define BPOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpoc assertion failed");

`endif

// ===== rtl/core/bpoc_pkg.sv =====
// shared constants and register codes for the box placement overlap check
// no dependencies
package bpoc_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int COORD_W   = 10;
    localparam int HALF_W    = 6;
    localparam int STORED_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    // signed width that holds a coordinate plus or minus the half size
    localparam int EDGE_W    = COORD_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_SIZE       = 3'd0,
        REG_OBSTACLE_LEFT   = 3'd1,
        REG_OBSTACLE_RIGHT  = 3'd2,
        REG_OBSTACLE_TOP    = 3'd3,
        REG_OBSTACLE_BOTTOM = 3'd4
    } cfg_reg_t;

    localparam logic [HALF_W-1:0]  HALF_SIZE_RST       = 6'd10;
    localparam logic [COORD_W-1:0] OBSTACLE_LEFT_RST   = 10'd300;
    localparam logic [COORD_W-1:0] OBSTACLE_RIGHT_RST  = 10'd340;
    localparam logic [COORD_W-1:0] OBSTACLE_TOP_RST    = 10'd230;
    localparam logic [COORD_W-1:0] OBSTACLE_BOTTOM_RST = 10'd250;

endpackage

// ===== rtl/core/box_placement_overlap_check.sv =====
// box placement overlap check: obstacle test, scan of stored centers, append
// depends on bpoc_pkg and assert_macros.svh
// flow: accept in idle, scan of the stored centers, result registered in finish
// new requests stall until the block is back in idle; a stalled
// result holds the next request in finish, and an overlap cuts the scan short
// reset: count cleared, config to defaults; center memory is only read below the count
`include "assert_macros.svh"

module box_placement_overlap_check (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bpoc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpoc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bpoc_pkg::COORD_W-1:0]      cursor_x,
    input  logic [bpoc_pkg::COORD_W-1:0]      cursor_y,
    input  logic                              place_request,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              can_place,
    output logic                              placed,
    output logic                              table_full,
    output logic [bpoc_pkg::STORED_W-1:0]     stored_count
);
    import bpoc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // configuration registers
    logic [HALF_W-1:0]  half_size_reg;
    logic [COORD_W-1:0] obs_left_reg;
    logic [COORD_W-1:0] obs_right_reg;
    logic [COORD_W-1:0] obs_top_reg;
    logic [COORD_W-1:0] obs_bottom_reg;

    // control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               free_reg, free_next;

    // latched request
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic               req_reg, req_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic               can_place_reg, can_place_next;
    logic               placed_reg, placed_next;
    logic               full_reg, full_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    // center memory, x in the upper half of each word
    logic [2*COORD_W-1:0] centre_mem [MAX_BOXES];
    logic [2*COORD_W-1:0] rd_data_reg;
    logic                 mem_rd;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic                 mem_wr;
    logic [IDX_W-1:0]     mem_wr_addr;

    logic               in_accept;
    logic               out_load;
    logic               obs_free;
    logic               stored_hit;
    logic               room;
    logic               do_place;

    // edges of the candidate box, signed so that cursor - half may go negative
    logic signed [EDGE_W-1:0] cand_l, cand_r, cand_t, cand_b;
    logic signed [EDGE_W-1:0] half_s;

    // stored box vs candidate: overlap when both center distances are at most 2*half
    logic signed [COORD_W:0]  dx, dy;
    logic [COORD_W-1:0]       adx, ady;
    logic [HALF_W:0]          span;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // obstacle test runs on the live input, captured at accept
    always_comb
    begin
        half_s  = $signed({{(EDGE_W-HALF_W){1'b0}}, half_size_reg});
        cand_l  = $signed({2'b00, cursor_x}) - half_s;
        cand_r  = $signed({2'b00, cursor_x}) + half_s;
        cand_t  = $signed({2'b00, cursor_y}) - half_s;
        cand_b  = $signed({2'b00, cursor_y}) + half_s;
        obs_free = (cand_l > $signed({2'b00, obs_right_reg}))
                || (cand_r < $signed({2'b00, obs_left_reg}))
                || (cand_t > $signed({2'b00, obs_bottom_reg}))
                || (cand_b < $signed({2'b00, obs_top_reg}));
    end

    always_comb
    begin
        dx   = $signed({1'b0, cx_reg}) - $signed({1'b0, rd_data_reg[2*COORD_W-1:COORD_W]});
        dy   = $signed({1'b0, cy_reg}) - $signed({1'b0, rd_data_reg[COORD_W-1:0]});
        adx  = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady  = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        span = {half_size_reg, 1'b0};
        stored_hit = (adx <= COORD_W'(span)) && (ady <= COORD_W'(span));
    end

    assign room     = (count_reg < CNT_W'(MAX_BOXES));
    assign do_place = free_reg && req_reg && room;

    // read one stored center per cycle while the box is still free
    assign mem_rd      = (state_reg == ST_SCAN) && free_reg && (rd_idx_reg < count_reg);
    assign mem_rd_addr = rd_idx_reg[IDX_W-1:0];
    assign mem_wr      = out_load && do_place;
    assign mem_wr_addr = count_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        rd_valid_next  = 1'b0;
        free_next      = free_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && out_stall;
        can_place_next = can_place_reg;
        placed_next    = placed_reg;
        full_next      = full_reg;
        out_count_next = out_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cx_next     = cursor_x;
                    cy_next     = cursor_y;
                    req_next    = place_request;
                    free_next   = obs_free;
                    rd_idx_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_valid_next = mem_rd;
                if (mem_rd)
                    rd_idx_next = rd_idx_reg + 1'b1;
                if (rd_valid_reg && stored_hit)
                    free_next = 1'b0;
                // pipe drained and nothing left to read
                if (!mem_rd && !rd_valid_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    can_place_next = free_reg;
                    placed_next    = do_place;
                    full_next      = free_reg && req_reg && !room;
                    count_next     = do_place ? count_reg + 1'b1 : count_reg;
                    out_count_next = do_place ? count_reg + 1'b1 : count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        free_reg      <= free_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        req_reg       <= req_next;
        can_place_reg <= can_place_next;
        placed_reg    <= placed_next;
        full_reg      <= full_next;
        out_count_reg <= out_count_next;
    end

    // center memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            centre_mem[mem_wr_addr] <= {cx_reg, cy_reg};
        if (mem_rd)
            rd_data_reg <= centre_mem[mem_rd_addr];
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_size_reg  <= HALF_SIZE_RST;
            obs_left_reg   <= OBSTACLE_LEFT_RST;
            obs_right_reg  <= OBSTACLE_RIGHT_RST;
            obs_top_reg    <= OBSTACLE_TOP_RST;
            obs_bottom_reg <= OBSTACLE_BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_SIZE:       half_size_reg  <= cfg_data[HALF_W-1:0];
                REG_OBSTACLE_LEFT:   obs_left_reg   <= cfg_data[COORD_W-1:0];
                REG_OBSTACLE_RIGHT:  obs_right_reg  <= cfg_data[COORD_W-1:0];
                REG_OBSTACLE_TOP:    obs_top_reg    <= cfg_data[COORD_W-1:0];
                REG_OBSTACLE_BOTTOM: obs_bottom_reg <= cfg_data[COORD_W-1:0];
                default:             ;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign can_place    = can_place_reg;
    assign placed       = placed_reg;
    assign table_full   = full_reg;
    assign stored_count = STORED_W'(out_count_reg);

    // table never grows past its depth
    `BPOC_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_BOXES))
    // read data only returns during a scan
    `BPOC_ASSERT_IMP(a_rd_in_scan, clk, rst_n, rd_valid_reg, state_reg == ST_SCAN)
    // a placed box was free and not refused as full
    `BPOC_ASSERT_IMP(a_placed, clk, rst_n, out_valid_reg && placed_reg, can_place_reg && !full_reg)
    // count only moves when a box is written
    `BPOC_ASSERT_IMP(a_count_step, clk, rst_n, $changed(count_reg), $past(mem_wr))

endmodule
